// ===== sv/isr_pkg.sv =====
// shared helpers for the rounded integer square root unit
`default_nettype none

package isr_pkg;

  // number of root cells: scan bit starts at the highest even position below the width
  function automatic int unsigned isr_steps(input int unsigned width);
    return ((width - 1) >> 1) + 1;
  endfunction

  // delay from an accepted request to its result strobe, through all cells and the rounding stage
  function automatic int unsigned isr_latency(input int unsigned width);
    return isr_steps(width) + 1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/isr_cell.sv =====
// one shift-subtract root cell: resolves one root bit per request and registers it
`default_nettype none

module isr_cell #(
  parameter int unsigned W        = 32,
  parameter int unsigned SCAN_POS = 30
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         vld_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] acc_i,
  output logic         vld_o,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] acc_o
);

  localparam logic [W-1:0] SCAN = {{(W-1){1'b0}}, 1'b1} << SCAN_POS;

  logic         vld_q;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] acc_q, acc_d;
  logic [W:0]   trial;

  // trial subtract of partial root plus scan bit
  always_comb begin
    trial = {1'b0, acc_i} + {1'b0, SCAN};
    rem_d = rem_i;
    acc_d = acc_i >> 1;
    if (trial <= {1'b0, rem_i}) begin
      rem_d = rem_i - trial[W-1:0];
      acc_d = (acc_i >> 1) + SCAN;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // payload moves on to the next cell every cycle
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign vld_o = vld_q;
  assign rem_o = rem_q;
  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== sv/isr_round.sv =====
// final rounding stage: bumps the root when the remainder exceeds it
`default_nettype none

module isr_round #(
  parameter int unsigned W      = 32,
  parameter int unsigned ROOT_W = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [W-1:0]      rem_i,
  input  logic [W-1:0]      acc_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              vld_q;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [W:0]        sum;

  // round to nearest, ties stay down
  always_comb begin
    sum = {1'b0, acc_i};
    if (acc_i < rem_i) begin
      sum = {1'b0, acc_i} + {{W{1'b0}}, 1'b1};
    end
    root_d = sum[ROOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
  end

  assign vld_o  = vld_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ===== sv/integer_square_root_rounded_unit.sv =====
// top level of the rounded integer square root unit
// A request is taken whenever start_i is high and busy_o is low; busy_o is high only
// during reset and the first cycle after it, so one radicand can enter every clock.
// Each request runs through a chain of root cells, one cell per root bit
// ((IN_WIDTH-1)/2 + 1 cells, 16 at the default width), then one rounding stage, and
// done_o pulses with root_o when the request leaves the rounding stage. Results come out
// in request order and are shown for one cycle only: the receiver cannot hold them, so
// it must take every strobe.
`default_nettype none

module integer_square_root_rounded_unit #(
  parameter int unsigned IN_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [IN_WIDTH-1:0]   radicand_i,
  output logic                  done_o,
  output logic [IN_WIDTH/2:0]   root_o
);

  import isr_pkg::*;

  localparam int unsigned STEPS   = isr_steps(IN_WIDTH);
  localparam int unsigned TOP_POS = 2 * (STEPS - 1);
  localparam int unsigned ROOT_W  = IN_WIDTH / 2 + 1;

  logic                busy_q;
  logic                vld_w [STEPS+1];
  logic [IN_WIDTH-1:0] rem_w [STEPS+1];
  logic [IN_WIDTH-1:0] acc_w [STEPS+1];

  // held busy through reset, cleared by the register in the cycle after reset is released
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;

  // chain head
  assign vld_w[0] = start_i & ~busy_q;
  assign rem_w[0] = radicand_i;
  assign acc_w[0] = '0;

  // row of root cells, scan bit moves down two places per cell
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    isr_cell #(
      .W        (IN_WIDTH),
      .SCAN_POS (TOP_POS - 2 * k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld_w[k]),
      .rem_i  (rem_w[k]),
      .acc_i  (acc_w[k]),
      .vld_o  (vld_w[k+1]),
      .rem_o  (rem_w[k+1]),
      .acc_o  (acc_w[k+1])
    );
  end

  // rounding and output register
  isr_round #(
    .W      (IN_WIDTH),
    .ROOT_W (ROOT_W)
  ) u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_w[STEPS]),
    .rem_i  (rem_w[STEPS]),
    .acc_i  (acc_w[STEPS]),
    .vld_o  (done_o),
    .root_o (root_o)
  );

endmodule

`default_nettype wire

// ===== sv/isr_checker.sv =====
// port-level checks for the rounded integer square root unit, bound to the top level
`default_nettype none

module isr_checker #(
  parameter int unsigned IN_WIDTH = 32
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic [IN_WIDTH-1:0] radicand_i,
  input logic                done_o,
  input logic [IN_WIDTH/2:0] root_o
);

  import isr_pkg::*;

  localparam int unsigned LAT = isr_latency(IN_WIDTH);

  // every request yields a strobe after the fixed latency
  a_req_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("request without result strobe");

  // no strobe without a matching request
  a_done_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result strobe without request");

  // zero radicand gives zero root
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && radicand_i == '0) |-> ##LAT (root_o == '0))
    else $error("nonzero root for zero radicand");

  // unit never refuses a request after the cycle following reset
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> !busy_o)
    else $error("busy outside reset");

endmodule

bind integer_square_root_rounded_unit isr_checker #(.IN_WIDTH(IN_WIDTH)) u_isr_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the rounded integer square root unit
`default_nettype none

module tb;

  import isr_pkg::*;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned ROOT_BITS = WIDTH / 2 + 1;
  localparam int unsigned PIPE_DEPTH = isr_latency(WIDTH);
  localparam int unsigned RANDOM_REQUESTS = 1950;
  localparam int unsigned MAX_GAP = 17;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned NUM_ROWS = 17;

  typedef logic [WIDTH-1:0] radicand_t;
  typedef logic [ROOT_BITS-1:0] root_t;

  // one pending root with the radicand it came from
  typedef struct packed {
    radicand_t radicand;
    root_t     root;
  } pending_root_t;

  // directed row: a root is typed in only where it is obvious
  typedef struct packed {
    radicand_t radicand;
    logic      typed;
    root_t     root;
  } sqrt_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  radicand_t radicand_i;
  logic      done_o;
  root_t     root_o;

  // root that the request now on the ports should give
  root_t     req_root;

  pending_root_t pending_roots[$];
  int unsigned   fails = 0;
  int unsigned   idle_cycles = 0;

  sqrt_row_t sqrt_rows [NUM_ROWS] = '{
    '{32'h0000_0000, 1'b1, 17'd0},
    '{32'h0000_0001, 1'b1, 17'd1},
    '{32'h0000_0002, 1'b1, 17'd1},      // halfway, stays down
    '{32'h0000_0003, 1'b1, 17'd2},
    '{32'h0000_0004, 1'b1, 17'd2},
    '{32'h0000_0006, 1'b1, 17'd2},      // halfway, stays down
    '{32'h0000_0007, 1'b1, 17'd3},
    '{32'h0001_0000, 1'b1, 17'd256},
    '{32'h4000_0000, 1'b1, 17'd32768},
    '{32'hFFFE_0001, 1'b1, 17'd65535},
    '{32'hFFFF_0000, 1'b1, 17'd65535},  // halfway at the top
    '{32'hFFFF_0001, 1'b1, 17'd65536},
    '{32'hFFFF_FFFF, 1'b1, 17'd65536},  // all ones rounds past 16 bits
    '{32'h8000_0000, 1'b0, 17'd0},
    '{32'h5555_5555, 1'b0, 17'd0},
    '{32'hAAAA_AAAA, 1'b0, 17'd0},
    '{32'h0000_FFFF, 1'b0, 17'd0}
  };

  integer_square_root_rounded_unit #(
    .IN_WIDTH(WIDTH)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .radicand_i(radicand_i),
    .done_o    (done_o),
    .root_o    (root_o)
  );

  // shift-subtract root with round to nearest, halfway stays down
  function automatic root_t rounded_root(input radicand_t radicand);
    logic [WIDTH:0] rem;
    logic [WIDTH:0] acc;
    logic [WIDTH:0] scan;
    logic [WIDTH:0] trial;
    rem  = {1'b0, radicand};
    acc  = '0;
    scan = '0;
    scan[((WIDTH - 1) / 2) * 2] = 1'b1;
    while (scan != 0) begin
      trial = acc + scan;
      acc   = acc >> 1;
      if (trial <= rem) begin
        rem = rem - trial;
        acc = acc + scan;
      end
      scan = scan >> 2;
    end
    if (acc < rem)
      acc = acc + 1;
    return acc[ROOT_BITS-1:0];
  endfunction

  // random radicand, biased toward squares, halfway points and the ends
  function automatic radicand_t pick_radicand();
    logic [63:0] k;
    logic [63:0] v;
    k = $urandom_range(0, 65535);
    case ($urandom_range(0, 9))
      4: v = k * k;
      5: v = k * k + k;
      6: v = k * k + k + 1;
      7: v = $urandom_range(0, 1023);
      8: v = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      9: v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    return v[WIDTH-1:0];
  endfunction

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // one request: idle for gap cycles, then hold start until it is taken
  task automatic send_request(input radicand_t radicand, input root_t root,
                              input int unsigned gap);
    if (gap > 0) begin
      start_i    <= 1'b0;
      radicand_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    radicand_i <= radicand;
    req_root   <= root;
    do @(posedge clk_i); while (busy_o);
  endtask

  // take requests into the store and check each strobe against the oldest
  always @(posedge clk_i) begin
    pending_root_t head;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_roots.size() == 0) begin
          $display("%0t: unexpected root strobe: expected none, actual %0d", $time, root_o);
          fails++;
        end else begin
          head = pending_roots.pop_front();
          if (root_o !== head.root) begin
            $display("%0t: root mismatch for radicand %h: expected %0d, actual %0d",
                     $time, head.radicand, head.root, root_o);
            fails++;
          end
        end
      end
      if (start_i && !busy_o)
        pending_roots.push_back('{radicand: radicand_i, root: req_root});
    end
  end

  // watchdog on cycles with neither request nor result
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    bit          burst;
    int unsigned gap;
    radicand_t   value;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    radicand_i  <= '0;
    req_root    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      gap = $urandom_range(0, MAX_GAP);
      send_request(sqrt_rows[i].radicand,
                   sqrt_rows[i].typed ? sqrt_rows[i].root
                                      : rounded_root(sqrt_rows[i].radicand),
                   gap);
    end

    // random requests, with back-to-back stretches
    burst = 1'b0;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 100 == 0)
        burst = ($urandom_range(0, 2) == 0);
      gap   = burst ? 0 : $urandom_range(0, MAX_GAP);
      value = pick_radicand();
      send_request(value, rounded_root(value), gap);
    end
    start_i <= 1'b0;

    // drain the pipe, then look for stray strobes
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);

    if (fails == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
